FILE: rtl/ccd_pkg.sv
// Package for the cylindrical charge deposit block: command, kind and register codes,
// queue entry and status types. No dependencies.
package ccd_pkg;

	localparam logic [1:0] CMD_DEPOSIT    = 2'd0;
	localparam logic [1:0] CMD_READ       = 2'd1;
	localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

	localparam logic [1:0] REG_ROWS    = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_SCALE   = 2'd2;

	localparam logic [1:0] KIND_NONE       = 2'd0;
	localparam logic [1:0] KIND_DEPOSIT    = 2'd1;
	localparam logic [1:0] KIND_READ       = 2'd2;
	localparam logic [1:0] KIND_READ_CLEAR = 2'd3;

	localparam int IDX_W = 12;
	localparam int WT_W  = 21;

	// mask bits: 0 own cell, 1 diagonal, 2 axial neighbor, 3 radial neighbor
	typedef struct packed {
		logic [1:0]                 kind;
		logic [IDX_W-1:0]           row;
		logic [IDX_W-1:0]           col;
		logic [IDX_W-1:0]           nrow;
		logic [IDX_W-1:0]           ncol;
		logic signed [31:0]         charge;
		logic [3:0]                 mask;
		logic [3:0][WT_W-1:0]       weight;
	} ccd_entry_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} ccd_status_t;

endpackage

FILE: rtl/ccd_if.sv
// Channel interfaces of the charge deposit block: input words, result words, config writes.
// Depends on nothing.
interface ccd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [19:0]        radial_position;
	logic [19:0]        axial_position;
	logic [7:0]         cell_row;
	logic [7:0]         cell_column;
	logic [1:0]         quadrant;
	logic signed [31:0] charge;
	modport source(output valid, command, radial_position, axial_position, cell_row,
		cell_column, quadrant, charge, input ready);
	modport sink(input valid, command, radial_position, axial_position, cell_row,
		cell_column, quadrant, charge, output ready);
endinterface

interface ccd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cell_charge;
	logic               saturated;
	modport source(output valid, cell_charge, saturated, input ready);
	modport sink(input valid, cell_charge, saturated, output ready);
endinterface

interface ccd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/ccd_front.sv
// Front end: accepts input words, classifies them, computes offsets and area weights.
// Depends on ccd_pkg and ccd_in_if.
module ccd_front #(
	parameter int MAX_ROWS      = 256,
	parameter int MAX_COLUMNS   = 256,
	parameter int FRACTION_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	ccd_in_if.sink              item,
	input  logic [8:0]          rows_in_use,
	input  logic [8:0]          columns_in_use,
	input  ccd_pkg::ccd_status_t status,
	input  logic                queue_full,
	output logic                push,
	output ccd_pkg::ccd_entry_t entry
);
	localparam int F = FRACTION_BITS;
	localparam logic [31:0] ONE   = 32'(1) << F;
	localparam logic [31:0] HALF  = 32'(1) << (F - 1);
	localparam logic [F:0]  UNIT  = {1'b1, {F{1'b0}}};
	localparam logic [15:0] MROWS = 16'(MAX_ROWS);
	localparam logic [15:0] MCOLS = 16'(MAX_COLUMNS);

	logic                      v_s1;
	logic [1:0]                kind_s1;
	logic [ccd_pkg::IDX_W-1:0] row_s1, col_s1, nrow_s1, ncol_s1;
	logic signed [31:0]        charge_s1;
	logic [3:0]                mask_s1;
	logic [F:0]                k_s1, e_s1;

	logic [15:0] rows_eff, cols_eff, row16, col16;
	logic        in_range, up, right, has_r, has_z, accept;
	logic [31:0] pr, pz, cr, cz, dr, dz;
	logic [F:0]  k, e;
	logic [1:0]  kind;

	function automatic logic [ccd_pkg::WT_W-1:0] area(input logic [F:0] a, input logic [F:0] b);
		logic [2*F+1:0] p;
		p = (2*F+2)'(a) * (2*F+2)'(b) + (2*F+2)'(HALF);
		return ccd_pkg::WT_W'(p >> F);
	endfunction

	function automatic logic [F:0] clamp(input logic [31:0] d);
		logic [F:0] r;
		if ($signed(d) < 0) r = '0;
		else if ($signed(d) > $signed(ONE)) r = UNIT;
		else r = d[F:0];
		return r;
	endfunction

	assign push       = v_s1 && !queue_full;
	assign item.ready = !status.clearing && (!v_s1 || !queue_full);
	assign accept     = item.valid && item.ready;

	always_comb begin
		rows_eff = ({7'b0, rows_in_use} > MROWS) ? MROWS : {7'b0, rows_in_use};
		cols_eff = ({7'b0, columns_in_use} > MCOLS) ? MCOLS : {7'b0, columns_in_use};
		row16    = {8'b0, item.cell_row};
		col16    = {8'b0, item.cell_column};
		in_range = (row16 < rows_eff) && (col16 < cols_eff);
		up       = !item.quadrant[1];
		right    = item.quadrant[0];
		pr       = {12'b0, item.radial_position};
		pz       = {12'b0, item.axial_position};
		cr       = ({24'b0, item.cell_row} << F) + HALF;
		cz       = ({24'b0, item.cell_column} << F) + HALF;
		dr       = up ? pr - cr : cr - pr;
		dz       = right ? pz - cz : cz - pz;
		k        = clamp(dr);
		e        = clamp(dz);
		has_r    = up ? (row16 + 16'd2 < rows_eff) : (item.cell_row != 8'd0);
		has_z    = right ? (col16 + 16'd2 < cols_eff) : (item.cell_column != 8'd0);
		unique case (item.command)
			ccd_pkg::CMD_DEPOSIT:    kind = in_range ? ccd_pkg::KIND_DEPOSIT : ccd_pkg::KIND_NONE;
			ccd_pkg::CMD_READ:       kind = in_range ? ccd_pkg::KIND_READ : ccd_pkg::KIND_NONE;
			ccd_pkg::CMD_READ_CLEAR: kind = in_range ? ccd_pkg::KIND_READ_CLEAR
				: ccd_pkg::KIND_NONE;
			default:                 kind = ccd_pkg::KIND_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			row_s1    <= ccd_pkg::IDX_W'(item.cell_row);
			col_s1    <= ccd_pkg::IDX_W'(item.cell_column);
			nrow_s1   <= up ? ccd_pkg::IDX_W'(item.cell_row) + 1'b1
				: ccd_pkg::IDX_W'(item.cell_row) - 1'b1;
			ncol_s1   <= right ? ccd_pkg::IDX_W'(item.cell_column) + 1'b1
				: ccd_pkg::IDX_W'(item.cell_column) - 1'b1;
			charge_s1 <= item.charge;
			k_s1      <= k;
			e_s1      <= e;
			mask_s1   <= (kind == ccd_pkg::KIND_DEPOSIT) ? {has_r, has_z, has_r & has_z, 1'b1}
				: 4'b0;
		end
	end

	always_comb begin
		entry.kind      = kind_s1;
		entry.row       = row_s1;
		entry.col       = col_s1;
		entry.nrow      = nrow_s1;
		entry.ncol      = ncol_s1;
		entry.charge    = charge_s1;
		entry.mask      = mask_s1;
		entry.weight[0] = area(UNIT - k_s1, UNIT - e_s1);
		entry.weight[1] = area(k_s1, e_s1);
		entry.weight[2] = area(e_s1, UNIT - k_s1);
		entry.weight[3] = area(k_s1, UNIT - e_s1);
	end
endmodule

FILE: rtl/ccd_queue.sv
// Two-entry queue between front and back ends.
// Depends on ccd_pkg.
module ccd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ccd_pkg::ccd_entry_t push_entry,
	input  logic                pop,
	output ccd_pkg::ccd_entry_t head,
	output logic                full,
	output logic                empty
);
	ccd_pkg::ccd_entry_t slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_entry;
	end
endmodule

FILE: rtl/ccd_back.sv
// Back end: share sequencer, scaling multipliers, radial divider, grid memory, result register.
// Depends on ccd_pkg and ccd_out_if.
module ccd_back #(
	parameter int MAX_ROWS      = 256,
	parameter int MAX_COLUMNS   = 256,
	parameter int FRACTION_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccd_pkg::ccd_entry_t  head,
	input  logic                 empty,
	output logic                 pop,
	input  logic [31:0]          scale,
	output ccd_pkg::ccd_status_t status,
	ccd_out_if.source            result
);
	localparam int F     = FRACTION_BITS;
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int DW    = RW + 1;
	localparam int NW    = 50;
	localparam int PW    = 32 + ccd_pkg::WT_W;
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);
	localparam logic [33:0]   CAP  = 34'(1) << 33;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PICK = 4'd2;
	localparam logic [3:0] S_MUL1 = 4'd3;
	localparam logic [3:0] S_RND  = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_DIVI = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_ACC  = 4'd8;
	localparam logic [3:0] S_RD1  = 4'd9;
	localparam logic [3:0] S_RD2  = 4'd10;
	localparam logic [3:0] S_RES  = 4'd11;

	logic [31:0] mem [DEPTH];

	logic [3:0]                state_q;
	logic [AW-1:0]             clr_q;
	logic [1:0]                kind_q;
	logic [RW-1:0]             row_q, nrow_q;
	logic [CW-1:0]             col_q, ncol_q;
	logic                      neg_q;
	logic [31:0]               qmag_q;
	logic [3:0]                mask_q;
	logic [3:0][ccd_pkg::WT_W-1:0] weight_q;
	logic [ccd_pkg::WT_W-1:0]  w_q;
	logic [AW-1:0]             addr_q;
	logic [DW-1:0]             d_q;
	logic [PW-1:0]             prod1_q;
	logic [31:0]               p_q;
	logic [63:0]               prod2_q;
	logic [NW-1:0]             quo_q;
	logic [DW-1:0]             rem_q;
	logic [5:0]                cnt_q;
	logic signed [31:0]        rd_q;
	logic signed [31:0]        value_q;
	logic                      sat_q;
	logic                      out_valid_q;
	logic signed [31:0]        out_charge_q;
	logic                      out_sat_q;

	logic [65:0]         n66;
	logic [DW:0]         rem_next;
	logic                rem_ge;
	logic [33:0]         share;
	logic signed [35:0]  sum;
	logic                sum_hi, sum_lo;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [31:0]         wdata;
	logic [1:0]          sel;

	assign pop             = (state_q == S_IDLE) && !empty;
	assign status.clearing = state_q == S_CLR;
	assign status.idle     = state_q == S_IDLE;
	assign result.valid    = out_valid_q;
	assign result.cell_charge = out_charge_q;
	assign result.saturated   = out_sat_q;

	always_comb begin
		n66      = {1'b0, prod2_q, 1'b0} + (66'(d_q) << 15);
		rem_next = {rem_q, quo_q[NW-1]};
		rem_ge   = rem_next >= (DW+1)'(d_q);
		share    = (quo_q > NW'(CAP)) ? CAP : quo_q[33:0];
		sum      = 36'(rd_q) + (neg_q ? -$signed({2'b0, share}) : $signed({2'b0, share}));
		sum_hi   = sum > 36'sd2147483647;
		sum_lo   = sum < -36'sd2147483648;
		if (mask_q[0]) sel = 2'd0;
		else if (mask_q[1]) sel = 2'd1;
		else if (mask_q[2]) sel = 2'd2;
		else sel = 2'd3;
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			S_ACC: begin
				we    = 1'b1;
				wdata = sum_hi ? 32'h7fffffff : sum_lo ? 32'h80000000 : sum[31:0];
			end
			S_RD2: we = kind_q == ccd_pkg::KIND_READ_CLEAR;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == S_RES) || (out_valid_q && !result.ready);
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!empty) begin
						unique case (head.kind)
							ccd_pkg::KIND_DEPOSIT:    state_q <= S_PICK;
							ccd_pkg::KIND_READ,
							ccd_pkg::KIND_READ_CLEAR: state_q <= S_RD1;
							default:                  state_q <= S_RES;
						endcase
					end
				end
				S_PICK: state_q <= (mask_q == 4'b0) ? S_RES : S_MUL1;
				S_MUL1: state_q <= S_RND;
				S_RND:  state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIVI;
				S_DIVI: state_q <= S_DIV;
				S_DIV:  if (cnt_q == 6'(NW - 1)) state_q <= S_ACC;
				S_ACC:  state_q <= S_PICK;
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_RES;
				S_RES: begin
					if (!out_valid_q || result.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q   <= head.kind;
				row_q    <= head.row[RW-1:0];
				col_q    <= head.col[CW-1:0];
				nrow_q   <= head.nrow[RW-1:0];
				ncol_q   <= head.ncol[CW-1:0];
				neg_q    <= head.charge < 0;
				qmag_q   <= (head.charge < 0) ? 32'(-head.charge) : 32'(head.charge);
				mask_q   <= head.mask;
				weight_q <= head.weight;
				addr_q   <= {head.row[RW-1:0], head.col[CW-1:0]};
				value_q  <= '0;
				sat_q    <= 1'b0;
			end
			S_PICK: begin
				w_q <= weight_q[sel];
				case (sel)
					2'd0: begin
						addr_q <= {row_q, col_q};
						d_q    <= {row_q, 1'b1};
					end
					2'd1: begin
						addr_q <= {nrow_q, ncol_q};
						d_q    <= {nrow_q, 1'b1};
					end
					2'd2: begin
						addr_q <= {row_q, ncol_q};
						d_q    <= {row_q, 1'b1};
					end
					default: begin
						addr_q <= {nrow_q, col_q};
						d_q    <= {nrow_q, 1'b1};
					end
				endcase
			end
			S_MUL1: prod1_q <= PW'(qmag_q) * PW'(w_q);
			S_RND:  p_q <= 32'((prod1_q + HALF) >> F);
			S_MUL2: prod2_q <= 64'(p_q) * 64'(scale);
			S_DIVI: begin
				quo_q <= n66[65:16];
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				quo_q <= {quo_q[NW-2:0], rem_ge};
				rem_q <= rem_ge ? DW'(rem_next - (DW+1)'(d_q)) : rem_next[DW-1:0];
				cnt_q <= cnt_q + 1'b1;
			end
			S_ACC: begin
				sat_q       <= sat_q | sum_hi | sum_lo;
				mask_q[sel] <= 1'b0;
			end
			S_RD2: value_q <= rd_q;
			S_RES: begin
				if (!out_valid_q || result.ready) begin
					out_charge_q <= value_q;
					out_sat_q    <= sat_q;
				end
			end
			default: cnt_q <= cnt_q;
		endcase
	end

`ifndef SYNTHESIS
	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !pop) else $error("queue popped during clear pass");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == S_PICK || state_q == S_RD1 || state_q == S_RES))
		else $error("bad state after pop");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q < 6'(NW))) else $error("divider overrun");
	a_read_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD2) |-> !sat_q) else $error("read word flagged saturated");
`endif
endmodule

FILE: rtl/cylindrical_charge_deposit_unit.sv
// Top level of the cylindrical charge deposit block: config registers, front, queue, back.
// Depends on ccd_pkg, ccd_if, ccd_front, ccd_queue and ccd_back.
//
// Usage:
//   item   : input words (deposit, read, read and clear), valid/ready.
//   result : one result word per input word, in order, valid/ready.
//   cfg    : register writes (rows in use, columns in use, deposit scale), always ready.
// After reset the grid memory is zeroed by a pass of 2^(clog2(MAX_ROWS)+clog2(MAX_COLUMNS))
// words (65536 by default); item.ready stays low during it.
// After the front register the back end reads a word, or reads and clears it, or deposits a
// charge in 1 to 4 shares: multiply, round, multiply, 50-step radial divider, update.
// The front takes a new word while the back is busy; a two-entry queue sits between them.
// A stalled result holds in its output register; the back end finishes the next word and
// waits, and the front keeps filling the queue until it is full.
module cylindrical_charge_deposit_unit #(
	parameter int MAX_ROWS      = 256,
	parameter int MAX_COLUMNS   = 256,
	parameter int FRACTION_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	ccd_in_if.sink     item,
	ccd_out_if.source  result,
	ccd_cfg_if.sink    cfg
);
	logic [8:0]  rows_q, cols_q;
	logic [31:0] scale_q;

	ccd_pkg::ccd_status_t status;
	ccd_pkg::ccd_entry_t  push_entry, head;
	logic push, pop, full, empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= 9'd256;
			cols_q  <= 9'd256;
			scale_q <= 32'd65536;
		end else if (cfg.valid) begin
			case (cfg.index)
				ccd_pkg::REG_ROWS:    rows_q  <= cfg.data[8:0];
				ccd_pkg::REG_COLUMNS: cols_q  <= cfg.data[8:0];
				ccd_pkg::REG_SCALE:   scale_q <= cfg.data;
				default:              scale_q <= scale_q;
			endcase
		end
	end

	ccd_front #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .item(item), .rows_in_use(rows_q),
		.columns_in_use(cols_q), .status(status), .queue_full(full),
		.push(push), .entry(push_entry)
	);

	ccd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_entry(push_entry),
		.pop(pop), .head(head), .full(full), .empty(empty)
	);

	ccd_back #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .empty(empty), .pop(pop),
		.scale(scale_q), .status(status), .result(result)
	);
endmodule
